// ----- rtl/lrs_pkg.sv -----
// ---------------------------------------------------------------------------
// lrs_pkg: shared types and constants of the decimal radix sorter
// Field widths of the stream channels, the controller to datapath command and
// status bundles, and the table of decimal digit weights.
// ---------------------------------------------------------------------------
`default_nettype none

package lrs_pkg;

   // Stream field widths
   localparam int KEY_FIELD_BITS = 31;
   localparam int IDX_BITS       = 6;
   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 40;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - KEY_FIELD_BITS - IDX_BITS;

   // Default sizing
   localparam int DEF_MAX_RECORDS = 64;
   localparam int DEF_KEY_BITS    = 31;

   // Decimal digit handling
   localparam int RADIX       = 10;
   localparam int DIGIT_BITS  = 4;
   localparam int PASS_BITS   = 4;
   localparam int WEIGHT_BITS = 34;
   localparam logic [PASS_BITS-1:0]  MAX_PASSES = PASS_BITS'(10);
   localparam logic [DIGIT_BITS-1:0] LAST_DIGIT = DIGIT_BITS'(RADIX - 1);

   // Reciprocal of ten: q / 10 == (q * RECIP_TEN) >> RECIP_SHIFT for any 32-bit q
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [PASS_BITS-1:0]  pass_type;

   // Controller to datapath
   typedef struct packed {
      logic      load;          // store the request beat at the load address
      logic      sort_rd;       // read issued into the digit pipeline
      logic      scatter;       // pipeline read belongs to the scatter walk
      logic      clear_counts;  // zero the ten buckets
      logic      prefix_en;     // add bucket prefix_idx-1 into prefix_idx
      digit_type prefix_idx;
      logic      src_bank;      // bank holding the current run order
      logic      emit_load;     // latch read data into the output register
      logic      emit_last;     // beat being latched closes the run
      logic      run_done;      // clear run bookkeeping
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic more_passes;  // largest key still has a digit at this pass
      logic pipe_busy;    // digit pipeline holds reads in flight
      logic beat_taken;   // output beat accepted this cycle
   } status_type;

   // Weight of decimal digit position pass
   function automatic logic [WEIGHT_BITS-1:0] pow10(input pass_type pass);
      logic [WEIGHT_BITS-1:0] w;
      case (pass)
         4'd0:    w = 34'd1;
         4'd1:    w = 34'd10;
         4'd2:    w = 34'd100;
         4'd3:    w = 34'd1000;
         4'd4:    w = 34'd10000;
         4'd5:    w = 34'd100000;
         4'd6:    w = 34'd1000000;
         4'd7:    w = 34'd10000000;
         4'd8:    w = 34'd100000000;
         4'd9:    w = 34'd1000000000;
         4'd10:   w = 34'd10000000000;
         default: w = '1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lsd_radix_sort_base10.sv -----
// ---------------------------------------------------------------------------
// lsd_radix_sort_base10: stable decimal LSD radix sorter for runs of keys
// Collects a run of keys, sorts it digit by digit and streams it back out.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one key per beat; tlast closes the run. A run also closes when
//            MAX_RECORDS keys are stored. req_tready is high only while the
//            block is collecting keys, one key per cycle.
//   rsp_*  : the sorted run, ascending, one beat per key with its arrival
//            index; tlast marks the final key. Equal keys keep arrival order.
//   Timing : after the closing key, each decimal digit of the largest key costs
//            one pass (count walk, drain, nine-step prefix sum, scatter walk,
//            drain), up to ten passes, limited by the single read port of the
//            key banks. Emission then reads, latches and offers each key in
//            turn, and waits for it to be accepted before reading the next.
//   Stalls : a held rsp_tready freezes emission on the current beat; nothing
//            is lost. The next run is taken after the final beat is accepted.
//   Reset  : synchronous, active high; the block returns to collecting with an
//            empty run. Key banks need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module lsd_radix_sort_base10 import lrs_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,   // key_in[30:0], zero pad[31]
   input  wire logic                     req_tlast,   // last_in
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,   // key_out[30:0], source_index[36:31]
   output logic                          rsp_tlast    // last_out
);

   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

   cmd_type       cmd;
   status_type    status;
   pass_type      pass;
   logic [AW-1:0] addr;

   lrs_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .status     (status),
      .cmd        (cmd),
      .pass       (pass),
      .addr       (addr)
   );

   lrs_datapath #(.MAX_RECORDS(MAX_RECORDS), .KEY_BITS(KEY_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .pass       (pass),
      .status     (status),
      .addr       (addr),
      .req_key    (req_tdata[KEY_FIELD_BITS-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/lrs_ram.sv -----
// ---------------------------------------------------------------------------
// lrs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module lrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read data
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- rtl/lrs_datapath.sv -----
// ---------------------------------------------------------------------------
// lrs_datapath: storage and arithmetic of the decimal radix sorter
// Two ping-pong key banks, the digit pipeline (read, divide by ten, bucket
// update), the ten bucket counters, largest-key tracking and the output beat.
// ---------------------------------------------------------------------------
`default_nettype none

module lrs_datapath import lrs_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   input  wire pass_type                  pass,       // digit position of this pass
   output status_type                     status,
   input  wire logic [AW-1:0]             addr,
   input  wire logic [KEY_FIELD_BITS-1:0] req_key,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,  // key_out[30:0], source_index[36:31]
   output logic                           rsp_tlast   // last_out
);

   localparam int CW         = $clog2(MAX_RECORDS + 1);
   localparam int ENTRY_BITS = 2 * KEY_BITS + IDX_BITS;

   // Entry layout: {key, arrival index, key divided by current weight}
   logic [KEY_BITS-1:0]   load_key;
   logic [ENTRY_BITS-1:0] load_entry;
   logic [ENTRY_BITS-1:0] scat_entry;
   logic [ENTRY_BITS-1:0] rdata0, rdata1, rdata_sel;
   logic                  we0, we1, scat_wr;
   logic [AW-1:0]         waddr0, pos;
   logic [ENTRY_BITS-1:0] wdata0;

   logic [KEY_BITS-1:0] rd_key, rd_q;
   logic [IDX_BITS-1:0] rd_idx;
   logic [63:0]         prod;
   logic [31:0]         quot_full;

   // Pipeline registers
   logic                v_a_ff, v_a_in, scat_a_ff;
   logic                v_b_ff, v_b_in, scat_b_ff;
   logic [KEY_BITS-1:0] key_b_ff, q_b_ff, quot_b_ff;
   logic [IDX_BITS-1:0] idx_b_ff;

   logic [31:0]     rem;
   digit_type       digit;
   logic [CW-1:0]   pos_full;
   logic [CW-1:0]   cnt_ff [RADIX];
   logic [CW-1:0]   cnt_in [RADIX];

   logic [KEY_BITS-1:0] largest_ff, largest_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0] key_o_ff;
   logic [IDX_BITS-1:0] idx_o_ff;
   logic                last_o_ff;

   assign load_key   = req_key[KEY_BITS-1:0];
   assign load_entry = {load_key, IDX_BITS'(addr), load_key};
   assign scat_entry = {key_b_ff, idx_b_ff, quot_b_ff};
   assign scat_wr    = v_b_ff && scat_b_ff;

   // Bank 0 takes loads and scatters from bank 1; bank 1 takes scatters from bank 0
   assign we0    = cmd.load || (scat_wr && cmd.src_bank);
   assign waddr0 = cmd.load ? addr : pos;
   assign wdata0 = cmd.load ? load_entry : scat_entry;
   assign we1    = scat_wr && !cmd.src_bank;

   lrs_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_RECORDS)) u_bank0 (
      .clock    (clock),
      .we       (we0),
      .waddr    (waddr0),
      .wdata    (wdata0),
      .raddr    (addr),
      .rdata_ff (rdata0)
   );

   lrs_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_RECORDS)) u_bank1 (
      .clock    (clock),
      .we       (we1),
      .waddr    (pos),
      .wdata    (scat_entry),
      .raddr    (addr),
      .rdata_ff (rdata1)
   );

   // Unpack the source bank
   assign rdata_sel = cmd.src_bank ? rdata1 : rdata0;
   assign rd_key    = rdata_sel[ENTRY_BITS-1 -: KEY_BITS];
   assign rd_idx    = rdata_sel[KEY_BITS +: IDX_BITS];
   assign rd_q      = rdata_sel[KEY_BITS-1:0];

   // Divide the quotient by ten through the reciprocal
   assign prod      = 64'(32'(rd_q)) * 64'(RECIP_TEN);
   assign quot_full = 32'(prod >> RECIP_SHIFT);

   // Digit is the remainder of that division
   assign rem      = 32'(q_b_ff) - (32'(quot_b_ff) << 3) - (32'(quot_b_ff) << 1);
   assign digit    = rem[DIGIT_BITS-1:0];
   assign pos_full = cnt_ff[digit] - CW'(1);
   assign pos      = pos_full[AW-1:0];

   assign v_a_in = cmd.sort_rd;
   assign v_b_in = v_a_ff;

   // Advance pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_b_ff <= v_b_in;
      end
   end

   // Advance pipeline payload
   always_ff @(posedge clock) begin
      scat_a_ff <= cmd.scatter;
      scat_b_ff <= scat_a_ff;
      key_b_ff  <= rd_key;
      idx_b_ff  <= rd_idx;
      q_b_ff    <= rd_q;
      quot_b_ff <= quot_full[KEY_BITS-1:0];
   end

   // Clear, prefix-sum, count up or take a slot
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_counts) begin
         for (int k = 0; k < RADIX; k++) begin
            cnt_in[k] = '0;
         end
      end else if (cmd.prefix_en) begin
         cnt_in[cmd.prefix_idx] = cnt_ff[cmd.prefix_idx] + cnt_ff[cmd.prefix_idx - 1'b1];
      end else if (v_b_ff) begin
         cnt_in[digit] = scat_b_ff ? pos_full : cnt_ff[digit] + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RADIX; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Track the largest key of the run
   always_comb begin
      largest_in = largest_ff;
      if (cmd.run_done) begin
         largest_in = '0;
      end else if (cmd.load && (load_key > largest_ff)) begin
         largest_in = load_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         largest_ff <= '0;
      end else begin
         largest_ff <= largest_in;
      end
   end

   // Hold the output beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         key_o_ff  <= rd_key;
         idx_o_ff  <= rd_idx;
         last_o_ff <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_BITS'(0), idx_o_ff, KEY_FIELD_BITS'(key_o_ff)};
   assign rsp_tlast  = last_o_ff;

   // Status back to the controller
   assign status.more_passes = (pass < MAX_PASSES) &&
                               (WEIGHT_BITS'(largest_ff) >= pow10(pass));
   assign status.pipe_busy   = v_a_ff || v_b_ff;
   assign status.beat_taken  = rsp_valid_ff && rsp_tready;

`ifndef SYNTH
   a_scatter_bucket_nonempty: assert property (@(posedge clock) disable iff (reset)
      (v_b_ff && scat_b_ff) |-> (cnt_ff[digit] != '0))
      else $error("scatter took a slot from an empty bucket");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> !rsp_valid_ff)
      else $error("output beat overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ----- rtl/lrs_ctrl.sv -----
// ---------------------------------------------------------------------------
// lrs_ctrl: sequencer of the decimal radix sorter
// Walks load, per-pass count / prefix / scatter, and emit phases, and issues
// addresses and commands to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module lrs_ctrl import lrs_pkg::*; #(
   parameter int MAX_RECORDS = DEF_MAX_RECORDS,
   localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_tlast,
   input  wire status_type status,
   output cmd_type         cmd,
   output pass_type        pass,
   output logic [AW-1:0]   addr
);

   localparam int CW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [9:0] {
      ST_LOAD      = 10'b00_0000_0001,
      ST_CHECK     = 10'b00_0000_0010,
      ST_COUNT     = 10'b00_0000_0100,
      ST_CDRAIN    = 10'b00_0000_1000,
      ST_PREFIX    = 10'b00_0001_0000,
      ST_SCATTER   = 10'b00_0010_0000,
      ST_SDRAIN    = 10'b00_0100_0000,
      ST_EMIT_RD   = 10'b00_1000_0000,
      ST_EMIT_LD   = 10'b01_0000_0000,
      ST_EMIT_WAIT = 10'b10_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   pass_type      pass_ff, pass_in;
   digit_type     pfx_ff, pfx_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] last_pos;
   logic          at_last;
   logic          accept;

   assign last_pos   = count_ff - CW'(1);
   assign at_last    = (CW'(ptr_ff) == last_pos);
   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign addr       = (state_ff == ST_LOAD) ? count_ff[AW-1:0] : ptr_ff;
   assign pass       = pass_ff;

   // Sequence the phases
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pass_in  = pass_ff;
      pfx_in   = pfx_ff;
      bank_in  = bank_ff;

      cmd            = '0;
      cmd.src_bank   = bank_ff;
      cmd.prefix_idx = pfx_ff;
      cmd.emit_last  = at_last;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load = 1'b1;
               count_in = count_ff + CW'(1);
               if (req_tlast || (count_ff == CW'(MAX_RECORDS - 1))) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            ptr_in = '0;
            if (status.more_passes) begin
               cmd.clear_counts = 1'b1;
               state_in         = ST_COUNT;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_COUNT: begin
            cmd.sort_rd = 1'b1;
            if (at_last) begin
               state_in = ST_CDRAIN;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ST_CDRAIN: begin
            if (!status.pipe_busy) begin
               pfx_in   = digit_type'(1);
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            cmd.prefix_en = 1'b1;
            if (pfx_ff == LAST_DIGIT) begin
               ptr_in   = last_pos[AW-1:0];
               state_in = ST_SCATTER;
            end else begin
               pfx_in = pfx_ff + digit_type'(1);
            end
         end
         ST_SCATTER: begin
            cmd.sort_rd = 1'b1;
            cmd.scatter = 1'b1;
            if (ptr_ff == '0) begin
               state_in = ST_SDRAIN;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         ST_SDRAIN: begin
            if (!status.pipe_busy) begin
               bank_in  = !bank_ff;
               pass_in  = pass_ff + pass_type'(1);
               state_in = ST_CHECK;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (status.beat_taken) begin
               if (at_last) begin
                  cmd.run_done = 1'b1;
                  count_in     = '0;
                  ptr_in       = '0;
                  pass_in      = '0;
                  bank_in      = 1'b0;
                  state_in     = ST_LOAD;
               end else begin
                  ptr_in   = ptr_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ptr_ff   <= '0;
         pass_ff  <= '0;
         pfx_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         pass_ff  <= pass_in;
         pfx_ff   <= pfx_in;
         bank_ff  <= bank_in;
      end
   end

`ifndef SYNTH
   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (state_ff == ST_CHECK))
      else $error("closing key did not start the sort");

   a_pass_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT) |-> (pass_ff < MAX_PASSES))
      else $error("digit pass beyond the cap");

   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SDRAIN && !status.pipe_busy) |=> (bank_ff != $past(bank_ff)))
      else $error("banks not swapped after a scatter walk");
`endif

endmodule

`default_nettype wire
